// ----- rtl/core/arpc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// arpc_pkg: shared types and constants
// Request codes, status codes and ARP header constants for the ARP cache.
// ----------------------------------------------------------------------------
package arpc_pkg;

    localparam logic [2:0] REQ_LEARN  = 3'd0;
    localparam logic [2:0] REQ_LOOKUP = 3'd1;
    localparam logic [2:0] REQ_DELETE = 3'd2;
    localparam logic [2:0] REQ_STATIC = 3'd3;
    localparam logic [2:0] REQ_TICK   = 3'd4;
    localparam logic [2:0] REQ_RXHDR  = 3'd5;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_MISS    = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    localparam logic [15:0] HTYPE_ETH  = 16'h0001;
    localparam logic [15:0] PTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  HLEN_ETH   = 8'd6;
    localparam logic [7:0]  PLEN_IPV4  = 8'd4;
    localparam logic [15:0] OP_REQUEST = 16'd1;
    localparam logic [15:0] OP_REPLY   = 16'd2;

    localparam int ENTRY_W = 32 + 48 + 4 + 1 + 16;  // ip, mac, dev, static, age

    typedef struct packed {
        logic [31:0] ip;
        logic [47:0] mac;
        logic [3:0]  dev;
        logic        stat;
        logic [15:0] age;
    } entry_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        hit;
        logic [47:0] result_mac;
        logic [31:0] result_ip;
        logic        reply_send;
        logic [47:0] reply_target_mac;
        logic [31:0] reply_target_ip;
        logic [3:0]  reply_device;
        logic [6:0]  expired_count;
    } result_t;

endpackage
`default_nettype wire

// ----- rtl/core/arpc_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// arpc_ram: generic single-port RAM
// One write or one read per cycle, registered read data.
// ----------------------------------------------------------------------------
module arpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire                      aclk,
    input  wire                      we,
    input  wire  [$clog2(DEPTH)-1:0] addr,
    input  wire  [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

// ----- rtl/core/arp_cache_with_aging.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// arp_cache_with_aging: ARP cache keyed by IPv4 address with tick aging
// Sequencer walks the entry RAM for every valid request; a search checks one entry per cycle.
// ----------------------------------------------------------------------------
// Sequence per item: a search scan of the entry RAM for learn, lookup, delete,
// static and rx-header requests, then a scan of the valid bits for a free slot
// on a learn miss; a tick instead reads, ages and writes back each entry in turn.
// Throughput: one item at a time; s_tready is high only when idle.
// Reset: synchronous active low; valid bits cleared at once, age_reload 300.
module arp_cache_with_aging #(
    parameter int CACHE_ENTRIES = 64,
    parameter int DEVICE_COUNT  = 16
) (
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          cfg_we,
    input  wire  [15:0]  cfg_wdata,
    input  wire          s_tvalid,
    output logic         s_tready,
    // tdata: ip_addr, mac_addr, device_id, hw_type, proto_type, hw_len,
    //        proto_len, opcode, src_ip, header_complete (+11 zero bits)
    input  wire  [191:0] s_tdata,
    // tuser: req_type
    input  wire  [2:0]   s_tuser,
    output logic         m_tvalid,
    input  wire          m_tready,
    // tdata: status, hit, result_mac, result_ip, reply_send,
    //        reply_target_mac, reply_target_ip, reply_device, expired_count
    //        (+1 zero bit)
    output logic [175:0] m_tdata
);
    import arpc_pkg::*;

    localparam int AW = $clog2(CACHE_ENTRIES);
    localparam int CW = AW + 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;  // search for key
    localparam logic [2:0] S_FREE  = 3'd2;  // search for free slot
    localparam logic [2:0] S_WRITE = 3'd3;
    localparam logic [2:0] S_TICK  = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0]  state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;      // read address issued
    logic        rd_vld_reg, rd_vld_next;  // rdata belongs to rd_idx_reg
    logic [AW-1:0] rd_idx_reg, rd_idx_next;
    logic [15:0] age_reload_reg;
    logic [CACHE_ENTRIES-1:0] valid_reg, valid_next;

    logic [2:0]  req_reg;
    logic [31:0] ip_reg, sip_reg;
    logic [47:0] mac_reg;
    logic [3:0]  dev_reg;
    logic [2:0]  req_next;
    logic [31:0] ip_next, sip_next;
    logic [47:0] mac_next;
    logic [3:0]  dev_next;

    logic [AW-1:0] hit_idx_reg, hit_idx_next;
    entry_t      hit_ent_reg, hit_ent_next;
    result_t     res_reg, res_next;

    logic        we;
    logic [AW-1:0] addr;
    entry_t      wdata, rdata;
    logic [ENTRY_W-1:0] rdata_raw;

    // unpack input item
    logic [31:0] in_ip, in_sip;
    logic [47:0] in_mac;
    logic [3:0]  in_dev;
    logic [15:0] in_htype, in_ptype, in_op;
    logic [7:0]  in_hlen, in_plen;
    logic        in_complete, hdr_ok, dev_ok;

    assign in_ip       = s_tdata[31:0];
    assign in_mac      = s_tdata[79:32];
    assign in_dev      = s_tdata[83:80];
    assign in_htype    = s_tdata[99:84];
    assign in_ptype    = s_tdata[115:100];
    assign in_hlen     = s_tdata[123:116];
    assign in_plen     = s_tdata[131:124];
    assign in_op       = s_tdata[147:132];
    assign in_sip      = s_tdata[179:148];
    assign in_complete = s_tdata[180];
    assign dev_ok = ({28'd0, in_dev} < 32'(DEVICE_COUNT));
    assign hdr_ok = in_complete && dev_ok && in_htype == HTYPE_ETH &&
                    in_ptype == PTYPE_IPV4 && in_hlen == HLEN_ETH &&
                    in_plen == PLEN_IPV4 && (in_op == OP_REQUEST || in_op == OP_REPLY);

    arpc_ram #(.WIDTH(ENTRY_W), .DEPTH(CACHE_ENTRIES)) u_ram (
        .aclk (aclk),
        .we   (we),
        .addr (addr),
        .wdata(wdata),
        .rdata(rdata_raw)
    );
    assign rdata = entry_t'(rdata_raw);

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata  = {1'b0, res_reg.expired_count, res_reg.reply_device,
                       res_reg.reply_target_ip, res_reg.reply_target_mac,
                       res_reg.reply_send, res_reg.result_ip, res_reg.result_mac,
                       res_reg.hit, res_reg.status};

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            age_reload_reg <= 16'd300;
        end else if (cfg_we) begin
            age_reload_reg <= cfg_wdata;
        end
    end

    // sequencer
    always_comb begin
        result_t r0;
        logic    matched;
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        rd_vld_next = 1'b0;
        rd_idx_next = rd_idx_reg;
        valid_next  = valid_reg;
        req_next = req_reg; ip_next = ip_reg; sip_next = sip_reg;
        mac_next = mac_reg; dev_next = dev_reg;
        hit_idx_next = hit_idx_reg;
        hit_ent_next = hit_ent_reg;
        res_next = res_reg;
        we    = 1'b0;
        addr  = cnt_reg[AW-1:0];
        wdata = hit_ent_reg;
        r0 = '0;
        matched = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    r0.status = ST_INVALID;
                    res_next  = r0;
                    mac_next  = in_mac;
                    dev_next  = in_dev;
                    sip_next  = in_sip;
                    cnt_next  = '0;
                    state_next = S_OUT;
                    case (s_tuser)
                        REQ_LEARN: begin
                            if (dev_ok) begin
                                req_next = REQ_LEARN; ip_next = in_ip;
                                state_next = S_SCAN;
                            end
                        end
                        REQ_LOOKUP, REQ_DELETE, REQ_STATIC: begin
                            req_next = s_tuser; ip_next = in_ip;
                            state_next = S_SCAN;
                        end
                        REQ_TICK: begin
                            req_next = REQ_TICK;
                            res_next.status = ST_OK;
                            state_next = S_TICK;
                        end
                        REQ_RXHDR: begin
                            if (hdr_ok) begin
                                if (in_op == OP_REPLY) begin
                                    req_next = REQ_LEARN; ip_next = in_sip;
                                end else begin
                                    req_next = REQ_RXHDR; ip_next = in_ip;
                                end
                                state_next = S_SCAN;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_SCAN: begin
                // issue reads, check the entry read last cycle
                if (rd_vld_reg && valid_reg[rd_idx_reg] && rdata.ip == ip_reg) begin
                    matched = 1'b1;
                end
                if (matched) begin
                    hit_idx_next = rd_idx_reg;
                    hit_ent_next = rdata;
                    res_next.status = ST_OK;
                    res_next.hit = 1'b1;
                    state_next = S_OUT;
                    case (req_reg)
                        REQ_LEARN: begin
                            if (!rdata.stat) begin
                                hit_ent_next.age = age_reload_reg;
                                hit_ent_next.dev = dev_reg;
                                hit_ent_next.mac = mac_reg;
                                state_next = S_WRITE;
                            end
                        end
                        REQ_LOOKUP: begin
                            res_next.result_mac = rdata.mac;
                            res_next.result_ip = rdata.ip;
                            res_next.reply_device = rdata.dev;
                        end
                        REQ_DELETE: valid_next[rd_idx_reg] = 1'b0;
                        REQ_STATIC: begin
                            hit_ent_next.stat = 1'b1;
                            state_next = S_WRITE;
                        end
                        REQ_RXHDR: begin
                            res_next.result_mac = rdata.mac;
                            res_next.result_ip = rdata.ip;
                            res_next.reply_send = 1'b1;
                            res_next.reply_target_mac = mac_reg;
                            res_next.reply_target_ip = sip_reg;
                            res_next.reply_device = dev_reg;
                        end
                        default: ;
                    endcase
                end else if (cnt_reg == CW'(CACHE_ENTRIES)) begin
                    // key absent
                    if (req_reg == REQ_LEARN) begin
                        cnt_next = '0;
                        state_next = S_FREE;
                    end else begin
                        res_next.status = ST_MISS;
                        state_next = S_OUT;
                    end
                end else begin
                    rd_vld_next = 1'b1;
                    rd_idx_next = cnt_reg[AW-1:0];
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_FREE: begin
                // lowest free slot from the valid bits, one per cycle
                if (cnt_reg == CW'(CACHE_ENTRIES)) begin
                    res_next.status = ST_FULL;
                    state_next = S_OUT;
                end else if (!valid_reg[cnt_reg[AW-1:0]]) begin
                    hit_idx_next = cnt_reg[AW-1:0];
                    hit_ent_next.ip = ip_reg;
                    hit_ent_next.mac = mac_reg;
                    hit_ent_next.dev = dev_reg;
                    hit_ent_next.stat = 1'b0;
                    hit_ent_next.age = age_reload_reg;
                    valid_next[cnt_reg[AW-1:0]] = 1'b1;
                    res_next.status = ST_OK;
                    state_next = S_WRITE;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_WRITE: begin
                we = 1'b1;
                addr = hit_idx_reg;
                wdata = hit_ent_reg;
                state_next = S_OUT;
            end
            S_TICK: begin
                // read entry k, then write back aged entry k next cycle, or invalidate it once its age is 1 or less
                if (rd_vld_reg) begin
                    addr = rd_idx_reg;
                    if (valid_reg[rd_idx_reg] && !rdata.stat) begin
                        if (rdata.age <= 16'd1) begin
                            valid_next[rd_idx_reg] = 1'b0;
                            if (res_reg.expired_count != 7'd127) begin
                                res_next.expired_count = res_reg.expired_count + 7'd1;
                            end
                        end else begin
                            we = 1'b1;
                            wdata = rdata;
                            wdata.age = rdata.age - 16'd1;
                        end
                    end
                end else if (cnt_reg == CW'(CACHE_ENTRIES)) begin
                    state_next = S_OUT;
                end else begin
                    rd_vld_next = 1'b1;
                    rd_idx_next = cnt_reg[AW-1:0];
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_OUT: begin
                if (m_tready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            rd_vld_reg <= 1'b0;
            valid_reg  <= '0;
        end else begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            rd_vld_reg <= rd_vld_next;
            valid_reg  <= valid_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        rd_idx_reg  <= rd_idx_next;
        req_reg     <= req_next;
        ip_reg      <= ip_next;
        sip_reg     <= sip_next;
        mac_reg     <= mac_next;
        dev_reg     <= dev_next;
        hit_idx_reg <= hit_idx_next;
        hit_ent_reg <= hit_ent_next;
        res_reg     <= res_next;
    end
endmodule
`default_nettype wire
